// ===== hdl/fta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fta_pkg
// Shared types and constants of the feed to axis speed unit.
// ----------------------------------------------------------------------------
package fta_pkg;

   localparam int FracBitsDefault = 16;
   localparam logic [30:0] SpeedMax = 31'h7FFF_FFFF;

   typedef enum logic [1:0] {
      CASE_RADIAL = 2'd0,
      CASE_ROTARY = 2'd1,
      CASE_AXIAL  = 2'd2
   } case_type;

   // Payload carried beside the square root chain.
   typedef struct packed {
      logic [30:0] fr;
      logic [62:0] mx;
      logic [62:0] mz;
      logic [62:0] ma;
      logic [6:0]  shift;
      case_type    kind;
   } side_type;

   // One division lane.
   typedef struct packed {
      logic [63:0] rem;
      logic [31:0] low;
      logic [31:0] quo;
      logic        zero;
      logic        ovf;
   } lane_type;

endpackage

// ===== hdl/fta_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fta_sqrt_cell
// One bit of a restoring integer square root, registered.
// ----------------------------------------------------------------------------
module fta_sqrt_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                valid_i,
   input  fta_pkg::side_type   side_i,
   input  logic [127:0]        rad_i,
   input  logic [65:0]         rem_i,
   input  logic [63:0]         root_i,
   output logic                valid_ff,
   output fta_pkg::side_type   side_ff,
   output logic [127:0]        rad_ff,
   output logic [65:0]         rem_ff,
   output logic [63:0]         root_ff
);
   import fta_pkg::*;

   logic [67:0] t;
   logic [67:0] trial;
   logic [67:0] diff;
   logic        ge;

   always_comb begin
      t     = {rem_i, rad_i[127:126]};
      trial = {2'b00, root_i, 2'b01};
      ge    = (t >= trial);
      diff  = t - trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
      if (en) begin
         side_ff <= side_i;
         rad_ff  <= {rad_i[125:0], 2'b00};
         rem_ff  <= ge ? diff[65:0] : t[65:0];
         root_ff <= {root_i[62:0], ge};
      end
   end

endmodule

// ===== hdl/fta_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fta_div_cell
// One quotient bit for three restoring division lanes sharing a divisor.
// ----------------------------------------------------------------------------
module fta_div_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                valid_i,
   input  fta_pkg::side_type   side_i,
   input  logic [63:0]         root_i,
   input  logic                rzero_i,
   input  fta_pkg::lane_type   lane_i [3],
   output logic                valid_ff,
   output fta_pkg::side_type   side_ff,
   output logic [63:0]         root_ff,
   output logic                rzero_ff,
   output fta_pkg::lane_type   lane_ff [3]
);
   import fta_pkg::*;

   lane_type lane_in [3];

   always_comb begin
      logic [64:0] t;
      logic        ge;
      for (int j = 0; j < 3; j++) begin
         t  = {lane_i[j].rem, lane_i[j].low[31]};
         ge = (t >= {1'b0, root_i});
         lane_in[j]     = lane_i[j];
         lane_in[j].rem = ge ? 64'(t - {1'b0, root_i}) : t[63:0];
         lane_in[j].low = {lane_i[j].low[30:0], 1'b0};
         lane_in[j].quo = {lane_i[j].quo[30:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
      if (en) begin
         side_ff  <= side_i;
         root_ff  <= root_i;
         rzero_ff <= rzero_i;
         lane_ff  <= lane_in;
      end
   end

endmodule

// ===== hdl/feed_to_axis_speed_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feed_to_axis_speed_unit
// Splits a path feedrate into x, z and a axis speeds for a tube machine.
// ----------------------------------------------------------------------------
// Usage: a transaction on the req_ stream carries one move (feedrate, start
// radius and the three deltas); exactly one transaction on the rsp_ stream
// returns the three absolute speeds on rsp_tdata, and the case taken and the
// saturation flag on rsp_tuser.
// Transactions leave in the order they arrive.
// The datapath is a pipeline of 8 front stages, a chain of 64 square root
// cells (one root bit per cell), one setup stage, a chain of 32 divider
// cells (one quotient bit per cell for all three axes) and an output stage.
// A new transaction is accepted every cycle while the receiver does not stall.
// Reset clears all valid bits; the pipeline is empty afterwards.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and req_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module feed_to_axis_speed_unit #(
   parameter int FRAC_BITS = fta_pkg::FracBitsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // feedrate, radius_start, delta_x, delta_z, delta_a, zero fill
   input  logic [159:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // speed_x, speed_z, speed_a, zero fill
   output logic [95:0]  rsp_tdata,
   // case_taken, saturated
   output logic [2:0]   rsp_tuser
);
   import fta_pkg::*;

   localparam int SqCells  = 64;
   localparam int DivCells = 32;
   localparam int ShW      = 63 + FRAC_BITS + 1 + 64;

   logic en;
   assign en         = !(rsp_tvalid && !rsp_tready);
   assign req_tready = en;

   // Stage 1: input registers.
   logic               v1_ff;
   logic [30:0]        fr1_ff;
   logic signed [31:0] rs1_ff, dx1_ff, dz1_ff, da1_ff;

   // Stage 2: magnitudes.
   logic               v2_ff;
   logic [30:0]        fr2_ff;
   logic [31:0]        adx2_ff, adz2_ff, ada2_ff;
   logic [32:0]        ar2_ff;
   case_type           kind2_ff;

   // Stage 3: products.
   logic               v3_ff;
   side_type           sd3_ff;
   logic [63:0]        p3_ff, dx2sq3_ff, dz2sq3_ff;

   // Stage 4: partial products of p squared.
   logic               v4_ff;
   side_type           sd4_ff;
   logic [63:0]        dx2sq4_ff, dz2sq4_ff, phh4_ff, phl4_ff, pll4_ff;

   // Stage 5: sum of squares.
   logic               v5_ff;
   side_type           sd5_ff;
   logic [127:0]       q5_ff;

   // Stage 6: leading chunk.
   logic               v6_ff;
   side_type           sd6_ff;
   logic [127:0]       q6_ff;
   logic [2:0]         idx6_ff;
   logic [15:0]        chunk6_ff;
   logic               nz6_ff;

   // Stage 7: normalizing shift.
   logic               v7_ff;
   side_type           sd7_ff;
   logic [127:0]       q7_ff;

   // Stage 8: normalized radicand.
   logic               v8_ff;
   side_type           sd8_ff;
   logic [127:0]       q8_ff;

   logic signed [33:0] r2_sum;
   logic [2:0]         idx_in;
   logic [15:0]        chunk_in;
   logic [3:0]         bit_in;
   logic [6:0]         shift_in;
   side_type           sd3_in;
   side_type           sd7_in;

   always_comb begin
      r2_sum   = {{2{rs1_ff[31]}}, rs1_ff} + {{2{rs1_ff[31]}}, rs1_ff}
               + {{2{dz1_ff[31]}}, dz1_ff};
      idx_in   = '0;
      chunk_in = '0;
      for (int k = 0; k < 8; k++) begin
         if (|q5_ff[k*16 +: 16]) begin
            idx_in   = 3'(k);
            chunk_in = q5_ff[k*16 +: 16];
         end
      end
      bit_in = '0;
      for (int b = 0; b < 16; b++) begin
         if (chunk6_ff[b]) begin
            bit_in = 4'(b);
         end
      end
      shift_in = nz6_ff ? (~{idx6_ff, bit_in}) >> 1 : 7'd0;

      sd3_in.fr    = fr2_ff;
      sd3_in.mx    = 63'({32'd0, fr2_ff} * {31'd0, adx2_ff});
      sd3_in.mz    = 63'({32'd0, fr2_ff} * {31'd0, adz2_ff});
      sd3_in.ma    = 63'({32'd0, fr2_ff} * {31'd0, ada2_ff});
      sd3_in.shift = '0;
      sd3_in.kind  = kind2_ff;

      sd7_in       = sd6_ff;
      sd7_in.shift = shift_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
      if (en) begin
         fr1_ff <= req_tdata[30:0];
         rs1_ff <= req_tdata[62:31];
         dx1_ff <= req_tdata[94:63];
         dz1_ff <= req_tdata[126:95];
         da1_ff <= req_tdata[158:127];

         fr2_ff  <= fr1_ff;
         adx2_ff <= dx1_ff[31] ? 32'(-dx1_ff) : 32'(dx1_ff);
         adz2_ff <= dz1_ff[31] ? 32'(-dz1_ff) : 32'(dz1_ff);
         ada2_ff <= da1_ff[31] ? 32'(-da1_ff) : 32'(da1_ff);
         ar2_ff  <= r2_sum[33] ? 33'(-r2_sum) : r2_sum[32:0];
         if (dz1_ff != 0) begin
            kind2_ff <= CASE_RADIAL;
         end else if (da1_ff != 0) begin
            kind2_ff <= CASE_ROTARY;
         end else begin
            kind2_ff <= CASE_AXIAL;
         end

         sd3_ff    <= sd3_in;
         p3_ff     <= 64'({31'd0, ar2_ff} * {32'd0, ada2_ff});
         dx2sq3_ff <= adx2_ff * adx2_ff;
         dz2sq3_ff <= adz2_ff * adz2_ff;

         sd4_ff    <= sd3_ff;
         dx2sq4_ff <= dx2sq3_ff;
         dz2sq4_ff <= dz2sq3_ff;
         phh4_ff   <= p3_ff[63:32] * p3_ff[63:32];
         phl4_ff   <= p3_ff[63:32] * p3_ff[31:0];
         pll4_ff   <= p3_ff[31:0] * p3_ff[31:0];

         sd5_ff <= sd4_ff;
         q5_ff  <= ({64'd0, dx2sq4_ff} << (2 * FRAC_BITS + 2))
                 + ({64'd0, dz2sq4_ff} << (2 * FRAC_BITS + 2))
                 + {phh4_ff, 64'd0}
                 + ({64'd0, phl4_ff} << 33)
                 + {64'd0, pll4_ff};

         sd6_ff    <= sd5_ff;
         q6_ff     <= q5_ff;
         idx6_ff   <= idx_in;
         chunk6_ff <= chunk_in;
         nz6_ff    <= (q5_ff != '0);

         sd7_ff <= sd7_in;
         q7_ff  <= q6_ff;

         sd8_ff <= sd7_ff;
         q8_ff  <= q7_ff << {sd7_ff.shift, 1'b0};
      end
   end

   // Square root chain.
   logic         sq_v    [SqCells+1];
   side_type     sq_sd   [SqCells+1];
   logic [127:0] sq_rad  [SqCells+1];
   logic [65:0]  sq_rem  [SqCells+1];
   logic [63:0]  sq_root [SqCells+1];

   assign sq_v[0]    = v8_ff;
   assign sq_sd[0]   = sd8_ff;
   assign sq_rad[0]  = q8_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar i = 0; i < SqCells; i++) begin : g_sq
      fta_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .valid_i  (sq_v[i]),
         .side_i   (sq_sd[i]),
         .rad_i    (sq_rad[i]),
         .rem_i    (sq_rem[i]),
         .root_i   (sq_root[i]),
         .valid_ff (sq_v[i+1]),
         .side_ff  (sq_sd[i+1]),
         .rad_ff   (sq_rad[i+1]),
         .rem_ff   (sq_rem[i+1]),
         .root_ff  (sq_root[i+1])
      );
   end

   // Divider setup.
   logic        dv_v_ff;
   side_type    dv_sd_ff;
   logic [63:0] dv_root_ff;
   logic        dv_rz_ff;
   lane_type    dv_lane_ff [3];
   lane_type    lane_in    [3];

   always_comb begin
      logic [62:0]    m;
      logic [ShW-1:0] sh;
      for (int j = 0; j < 3; j++) begin
         m  = (j == 0) ? sq_sd[SqCells].mx :
              (j == 1) ? sq_sd[SqCells].mz : sq_sd[SqCells].ma;
         sh = {{(ShW-63){1'b0}}, m} << (FRAC_BITS + 1 + int'(sq_sd[SqCells].shift));
         lane_in[j].rem  = {1'b0, sh[94:32]};
         lane_in[j].low  = sh[31:0];
         lane_in[j].quo  = '0;
         lane_in[j].zero = (m == '0);
         lane_in[j].ovf  = (sh[ShW-1:95] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff <= 1'b0;
      end else if (en) begin
         dv_v_ff <= sq_v[SqCells];
      end
      if (en) begin
         dv_sd_ff   <= sq_sd[SqCells];
         dv_root_ff <= sq_root[SqCells];
         dv_rz_ff   <= (sq_root[SqCells] == '0);
         dv_lane_ff <= lane_in;
      end
   end

   // Division chain.
   logic        d_v    [DivCells+1];
   side_type    d_sd   [DivCells+1];
   logic [63:0] d_root [DivCells+1];
   logic        d_rz   [DivCells+1];
   lane_type    d_lane [DivCells+1][3];

   assign d_v[0]    = dv_v_ff;
   assign d_sd[0]   = dv_sd_ff;
   assign d_root[0] = dv_root_ff;
   assign d_rz[0]   = dv_rz_ff;
   assign d_lane[0] = dv_lane_ff;

   for (genvar i = 0; i < DivCells; i++) begin : g_div
      fta_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .valid_i  (d_v[i]),
         .side_i   (d_sd[i]),
         .root_i   (d_root[i]),
         .rzero_i  (d_rz[i]),
         .lane_i   (d_lane[i]),
         .valid_ff (d_v[i+1]),
         .side_ff  (d_sd[i+1]),
         .root_ff  (d_root[i+1]),
         .rzero_ff (d_rz[i+1]),
         .lane_ff  (d_lane[i+1])
      );
   end

   // Output stage.
   logic [30:0] spd   [3];
   logic        sat_j [3];
   logic        out_v_ff;
   logic [95:0] out_ff;

   always_comb begin
      lane_type ln;
      for (int j = 0; j < 3; j++) begin
         ln = d_lane[DivCells][j];
         if (ln.zero) begin
            spd[j]   = '0;
            sat_j[j] = 1'b0;
         end else if (d_rz[DivCells] || ln.ovf || ln.quo[31]) begin
            spd[j]   = SpeedMax;
            sat_j[j] = 1'b1;
         end else begin
            spd[j]   = ln.quo[30:0];
            sat_j[j] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= d_v[DivCells];
      end
      if (en) begin
         if (d_sd[DivCells].kind == CASE_AXIAL) begin
            out_ff <= {1'b0, CASE_AXIAL, 31'd0, 31'd0, d_sd[DivCells].fr};
         end else begin
            out_ff <= {sat_j[0] | sat_j[1] | sat_j[2], d_sd[DivCells].kind,
                       spd[2], spd[1], spd[0]};
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {3'b000, out_ff[92:0]};
   assign rsp_tuser  = out_ff[95:93];

endmodule
